[sv/rv64i_decode_register_read_assert.svh]
// Assertion macros for the RV64I decode and register read block.
// Included by the top level; needs no other file.
`ifndef RV64I_DECODE_REGISTER_READ_ASSERT_SVH
`define RV64I_DECODE_REGISTER_READ_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define RV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RV_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RV_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/rv64dr_pkg.sv]
// Types, class codes and decode helpers for the RV64I decode and register read block.
// Has no dependencies.
`timescale 1ns / 1ps

package rv64dr_pkg;

  localparam int REG_IDX_W = 5;

  localparam logic REQ_DECODE = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  localparam logic [3:0] CLS_LOAD    = 4'd0;
  localparam logic [3:0] CLS_STORE   = 4'd1;
  localparam logic [3:0] CLS_BRANCH  = 4'd2;
  localparam logic [3:0] CLS_JALR    = 4'd3;
  localparam logic [3:0] CLS_JAL     = 4'd4;
  localparam logic [3:0] CLS_OPIMM   = 4'd5;
  localparam logic [3:0] CLS_OP      = 4'd6;
  localparam logic [3:0] CLS_AUIPC   = 4'd7;
  localparam logic [3:0] CLS_LUI     = 4'd8;
  localparam logic [3:0] CLS_OPIMM32 = 4'd9;
  localparam logic [3:0] CLS_OP32    = 4'd10;
  localparam logic [3:0] CLS_SYSTEM  = 4'd11;
  localparam logic [3:0] CLS_UNIMPL  = 4'd12;

  localparam logic [1:0] QUAD_WIDE = 2'b11;

  typedef struct packed {
    logic                 req_type;
    logic [31:0]          instr;
    logic [4:0]           reg_index;
    logic signed [63:0]   write_value;
  } in_item_t;

  typedef struct packed {
    logic                 not_wide_instr;
    logic [3:0]           op_class;
    logic [4:0]           dest_reg;
    logic [2:0]           func3_field;
    logic [6:0]           func7_field;
    logic signed [31:0]   immediate;
    logic signed [63:0]   left_operand;
    logic signed [63:0]   right_operand;
  } out_item_t;

  // Maps opcode bits [6:2] to an operation class.
  function automatic logic [3:0] class_of(input logic [4:0] opc);
    logic [3:0] cls;
    unique case (opc)
      5'b00000: cls = CLS_LOAD;
      5'b00100: cls = CLS_OPIMM;
      5'b00101: cls = CLS_AUIPC;
      5'b00110: cls = CLS_OPIMM32;
      5'b01000: cls = CLS_STORE;
      5'b01100: cls = CLS_OP;
      5'b01101: cls = CLS_LUI;
      5'b01110: cls = CLS_OP32;
      5'b11000: cls = CLS_BRANCH;
      5'b11001: cls = CLS_JALR;
      5'b11011: cls = CLS_JAL;
      5'b11100: cls = CLS_SYSTEM;
      default:  cls = CLS_UNIMPL;
    endcase
    return cls;
  endfunction

endpackage

[sv/rv64dr_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Payload types come from rv64dr_pkg through the type parameter.
`timescale 1ns / 1ps

interface rv64dr_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/rv64dr_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// Has no dependencies.
`timescale 1ns / 1ps

module rv64dr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[sv/rv64i_decode_register_read.sv]
// RV64I decode stage with its integer register file.
// Depends on rv64dr_pkg, rv64dr_stream_if, rv64dr_ram and the assertion header.
`timescale 1ns / 1ps
//
// Usage:
// - req carries items of two kinds. A write item (req_type = 1) stores
//   write_value into register reg_index and produces no result. A decode item
//   (req_type = 0) decodes instr and produces exactly one result on rsp.
// - Writes to x0 or to a register at or above REG_COUNT are dropped; reads of
//   such registers give zero. A write is visible to the very next decode item.
// - A decode item is read from the register file into the read stage when it
//   is accepted, then decoded into the output register, which drives rsp; a
//   stall on rsp can hold it in the read stage.
// - One item per cycle while rsp does not stall, set by the register file read
//   and the output register; both kinds of item may follow back to back.
// - When rsp stalls, the result waits in the output register and one more
//   decode item can still be taken into the read stage; req.ready drops only
//   when both are full and rsp.ready is low.
// - Reset (rst, synchronous) empties both stages and marks every register as
//   unwritten: an unwritten register reads zero, except x2, which reads
//   STACK_TOP. No clearing pass is needed.

module rv64i_decode_register_read #(
  parameter int          REG_COUNT = 32,
  parameter logic [63:0] STACK_TOP = 64'd262144
) (
  input  logic             clk,
  input  logic             rst,
  rv64dr_stream_if.sink    req,
  rv64dr_stream_if.source  rsp
);

  `include "rv64i_decode_register_read_assert.svh"

  localparam int IDX_W = $clog2(REG_COUNT);
  localparam int RIW   = rv64dr_pkg::REG_IDX_W;
  localparam logic [RIW:0] REG_LIMIT = (RIW + 1)'(REG_COUNT);
  localparam logic [RIW-1:0] SP_IDX  = RIW'(2);

  rv64dr_pkg::in_item_t  in_item;
  rv64dr_pkg::out_item_t out_data;
  rv64dr_pkg::out_item_t dec_next;

  logic                  dec_acc;
  logic                  wr_acc;
  logic                  out_load;
  logic                  out_valid;
  logic                  s1_valid;
  logic [31:0]           s1_instr;
  logic                  s1_rs1_live;
  logic                  s1_rs2_live;
  logic                  s1_rs1_written;
  logic                  s1_rs2_written;
  logic [REG_COUNT-1:0]  reg_valid;
  logic [RIW-1:0]        in_rs1;
  logic [RIW-1:0]        in_rs2;
  logic                  wr_live;
  logic [63:0]           ram_a;
  logic [63:0]           ram_b;
  logic [63:0]           rs1_value;
  logic [63:0]           rs2_value;

  assign in_item  = req.data;
  assign in_rs1   = in_item.instr[19:15];
  assign in_rs2   = in_item.instr[24:20];

  assign out_load  = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || out_load;
  assign dec_acc   = req.valid && req.ready && (in_item.req_type == rv64dr_pkg::REQ_DECODE);
  assign wr_acc    = req.valid && req.ready && (in_item.req_type == rv64dr_pkg::REQ_WRITE);
  assign wr_live   = (in_item.reg_index != '0) && ({1'b0, in_item.reg_index} < REG_LIMIT);

  rv64dr_ram #(
    .WIDTH (64),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .we      (wr_acc && wr_live),
    .waddr   (in_item.reg_index[IDX_W-1:0]),
    .wdata   (in_item.write_value),
    .re      (dec_acc),
    .raddr_a (in_rs1[IDX_W-1:0]),
    .raddr_b (in_rs2[IDX_W-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (wr_acc && wr_live) begin
      reg_valid[in_item.reg_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Read stage: holds the instruction while the register file output is live.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (dec_acc) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_acc) begin
      s1_instr       <= in_item.instr;
      s1_rs1_live    <= (in_rs1 != '0) && ({1'b0, in_rs1} < REG_LIMIT);
      s1_rs2_live    <= (in_rs2 != '0) && ({1'b0, in_rs2} < REG_LIMIT);
      s1_rs1_written <= reg_valid[in_rs1[IDX_W-1:0]];
      s1_rs2_written <= reg_valid[in_rs2[IDX_W-1:0]];
    end
  end

  // An unwritten register holds its reset value: STACK_TOP for x2, else zero.
  always_comb begin
    if (!s1_rs1_live) begin
      rs1_value = '0;
    end else if (s1_rs1_written) begin
      rs1_value = ram_a;
    end else if (s1_instr[19:15] == SP_IDX) begin
      rs1_value = STACK_TOP;
    end else begin
      rs1_value = '0;
    end
    if (!s1_rs2_live) begin
      rs2_value = '0;
    end else if (s1_rs2_written) begin
      rs2_value = ram_b;
    end else if (s1_instr[24:20] == SP_IDX) begin
      rs2_value = STACK_TOP;
    end else begin
      rs2_value = '0;
    end
  end

  always_comb begin
    logic [31:0] i;
    logic [3:0]  cls;
    i   = s1_instr;
    cls = rv64dr_pkg::class_of(i[6:2]);
    dec_next = '0;
    if (i[1:0] != rv64dr_pkg::QUAD_WIDE) begin
      dec_next.not_wide_instr = 1'b1;
    end else begin
      dec_next.op_class    = cls;
      dec_next.dest_reg    = i[11:7];
      dec_next.func3_field = i[14:12];
      unique case (cls)
        rv64dr_pkg::CLS_LOAD, rv64dr_pkg::CLS_JALR, rv64dr_pkg::CLS_OPIMM,
        rv64dr_pkg::CLS_OPIMM32, rv64dr_pkg::CLS_SYSTEM: begin
          dec_next.immediate    = {{20{i[31]}}, i[31:20]};
          dec_next.left_operand = rs1_value;
        end
        rv64dr_pkg::CLS_STORE: begin
          dec_next.dest_reg      = '0;
          dec_next.immediate     = {{20{i[31]}}, i[31:25], i[11:7]};
          dec_next.left_operand  = rs1_value;
          dec_next.right_operand = rs2_value;
        end
        rv64dr_pkg::CLS_BRANCH: begin
          dec_next.dest_reg      = '0;
          dec_next.immediate     = {{19{i[31]}}, i[31], i[7], i[30:25], i[11:8], 1'b0};
          dec_next.left_operand  = rs1_value;
          dec_next.right_operand = rs2_value;
        end
        rv64dr_pkg::CLS_JAL: begin
          dec_next.func3_field = '0;
          dec_next.immediate   = {{11{i[31]}}, i[31], i[19:12], i[20], i[30:21], 1'b0};
        end
        rv64dr_pkg::CLS_AUIPC, rv64dr_pkg::CLS_LUI: begin
          dec_next.func3_field = '0;
          dec_next.immediate   = {i[31:12], 12'b0};
        end
        rv64dr_pkg::CLS_OP, rv64dr_pkg::CLS_OP32: begin
          dec_next.func7_field   = i[31:25];
          dec_next.left_operand  = rs1_value;
          dec_next.right_operand = rs2_value;
        end
        default: begin
          dec_next.op_class    = rv64dr_pkg::CLS_UNIMPL;
          dec_next.dest_reg    = '0;
          dec_next.func3_field = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= dec_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  `RV_ASSERT_IMPLIES(a_full_stall_blocks_input, clk, rst,
    s1_valid && out_valid && !rsp.ready, !req.ready)
  `RV_ASSERT_NEXT(a_decode_enters_read_stage, clk, rst, dec_acc, s1_valid)
  `RV_ASSERT_IMPLIES(a_short_instr_zero_fields, clk, rst,
    out_valid && out_data.not_wide_instr,
    out_data.op_class == rv64dr_pkg::CLS_LOAD && out_data.left_operand == '0 &&
    out_data.right_operand == '0 && out_data.immediate == '0)

endmodule

[test/rv64i_decode_register_read_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rv64i_decode_register_read: decodes and register writes go in
// on req, and each decode result is checked against a shadow register file and decoder.
// Depends on rv64dr_pkg, rv64dr_stream_if and the rv64i_decode_register_read RTL.

module rv64i_decode_register_read_tb;

  localparam logic [63:0] STACK_TOP_VAL = 64'd262144;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 1500;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES   = 200;

  localparam logic [6:0] OPC_LOAD    = 7'b0000011;
  localparam logic [6:0] OPC_OPIMM   = 7'b0010011;
  localparam logic [6:0] OPC_AUIPC   = 7'b0010111;
  localparam logic [6:0] OPC_OPIMM32 = 7'b0011011;
  localparam logic [6:0] OPC_STORE   = 7'b0100011;
  localparam logic [6:0] OPC_OP      = 7'b0110011;
  localparam logic [6:0] OPC_LUI     = 7'b0110111;
  localparam logic [6:0] OPC_OP32    = 7'b0111011;
  localparam logic [6:0] OPC_BRANCH  = 7'b1100011;
  localparam logic [6:0] OPC_JALR    = 7'b1100111;
  localparam logic [6:0] OPC_JAL     = 7'b1101111;
  localparam logic [6:0] OPC_SYSTEM  = 7'b1110011;

  class decode_scoreboard;
    logic [63:0]           shadow_regs[32];
    rv64dr_pkg::out_item_t pending_decodes[$];
    int unsigned           failures;

    function new();
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      shadow_regs[2] = STACK_TOP_VAL;
      failures = 0;
    endfunction

    function logic [63:0] read_shadow(logic [4:0] idx);
      return (idx == 5'd0) ? 64'd0 : shadow_regs[idx];
    endfunction

    function rv64dr_pkg::out_item_t predict_decode(logic [31:0] ins);
      rv64dr_pkg::out_item_t res;
      logic [3:0]            cls;
      res = '0;
      if (ins[1:0] != rv64dr_pkg::QUAD_WIDE) begin
        res.not_wide_instr = 1'b1;
        return res;
      end
      case (ins[6:2])
        OPC_LOAD[6:2]:    cls = rv64dr_pkg::CLS_LOAD;
        OPC_STORE[6:2]:   cls = rv64dr_pkg::CLS_STORE;
        OPC_BRANCH[6:2]:  cls = rv64dr_pkg::CLS_BRANCH;
        OPC_JALR[6:2]:    cls = rv64dr_pkg::CLS_JALR;
        OPC_JAL[6:2]:     cls = rv64dr_pkg::CLS_JAL;
        OPC_OPIMM[6:2]:   cls = rv64dr_pkg::CLS_OPIMM;
        OPC_OP[6:2]:      cls = rv64dr_pkg::CLS_OP;
        OPC_AUIPC[6:2]:   cls = rv64dr_pkg::CLS_AUIPC;
        OPC_LUI[6:2]:     cls = rv64dr_pkg::CLS_LUI;
        OPC_OPIMM32[6:2]: cls = rv64dr_pkg::CLS_OPIMM32;
        OPC_OP32[6:2]:    cls = rv64dr_pkg::CLS_OP32;
        OPC_SYSTEM[6:2]:  cls = rv64dr_pkg::CLS_SYSTEM;
        default:          cls = rv64dr_pkg::CLS_UNIMPL;
      endcase
      res.op_class = cls;
      if (cls == rv64dr_pkg::CLS_UNIMPL) return res;
      res.dest_reg    = ins[11:7];
      res.func3_field = ins[14:12];
      case (cls)
        rv64dr_pkg::CLS_STORE: begin
          res.dest_reg      = '0;
          res.immediate     = {{20{ins[31]}}, ins[31:25], ins[11:7]};
          res.left_operand  = read_shadow(ins[19:15]);
          res.right_operand = read_shadow(ins[24:20]);
        end
        rv64dr_pkg::CLS_BRANCH: begin
          res.dest_reg      = '0;
          res.immediate     = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
          res.left_operand  = read_shadow(ins[19:15]);
          res.right_operand = read_shadow(ins[24:20]);
        end
        rv64dr_pkg::CLS_JAL: begin
          res.func3_field = '0;
          res.immediate   = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        end
        rv64dr_pkg::CLS_AUIPC, rv64dr_pkg::CLS_LUI: begin
          res.func3_field = '0;
          res.immediate   = {ins[31:12], 12'd0};
        end
        rv64dr_pkg::CLS_OP, rv64dr_pkg::CLS_OP32: begin
          res.func7_field   = ins[31:25];
          res.left_operand  = read_shadow(ins[19:15]);
          res.right_operand = read_shadow(ins[24:20]);
        end
        default: begin
          res.immediate    = {{20{ins[31]}}, ins[31:20]};
          res.left_operand = read_shadow(ins[19:15]);
        end
      endcase
      return res;
    endfunction

    // Called for every accepted transfer on req, in order of acceptance.
    function void note_request(rv64dr_pkg::in_item_t it);
      if (it.req_type == rv64dr_pkg::REQ_WRITE) begin
        if (it.reg_index != 5'd0) shadow_regs[it.reg_index] = it.write_value;
      end else begin
        pending_decodes.push_back(predict_decode(it.instr));
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        $error("%s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_decoded(rv64dr_pkg::out_item_t got);
      rv64dr_pkg::out_item_t want;
      if (pending_decodes.size() == 0) begin
        failures++;
        $error("decode result arrived with none outstanding");
        return;
      end
      want = pending_decodes.pop_front();
      compare_field("not_wide_instr", 64'(want.not_wide_instr), 64'(got.not_wide_instr));
      compare_field("op_class", 64'(want.op_class), 64'(got.op_class));
      compare_field("dest_reg", 64'(want.dest_reg), 64'(got.dest_reg));
      compare_field("func3_field", 64'(want.func3_field), 64'(got.func3_field));
      compare_field("func7_field", 64'(want.func7_field), 64'(got.func7_field));
      compare_field("immediate", 64'(want.immediate), 64'(got.immediate));
      compare_field("left_operand", want.left_operand, got.left_operand);
      compare_field("right_operand", want.right_operand, got.right_operand);
    endfunction

    function int outstanding();
      return pending_decodes.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  rv64dr_stream_if #(.T(rv64dr_pkg::in_item_t))  req_ch ();
  rv64dr_stream_if #(.T(rv64dr_pkg::out_item_t)) rsp_ch ();

  rv64i_decode_register_read #(
    .REG_COUNT(32),
    .STACK_TOP(STACK_TOP_VAL)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  decode_scoreboard sb;
  bit               tx_idle_on;
  bit               rx_idle_on;
  int unsigned      rx_hold_left;
  int unsigned      cycle_count;

  logic [4:0] well_formed_ops[12] = '{
    OPC_LOAD[6:2], OPC_STORE[6:2], OPC_BRANCH[6:2], OPC_JALR[6:2], OPC_JAL[6:2],
    OPC_OPIMM[6:2], OPC_OP[6:2], OPC_AUIPC[6:2], OPC_LUI[6:2], OPC_OPIMM32[6:2],
    OPC_OP32[6:2], OPC_SYSTEM[6:2]
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic rv64dr_pkg::in_item_t make_write(logic [4:0] idx, logic [63:0] val);
    rv64dr_pkg::in_item_t it;
    it.req_type    = rv64dr_pkg::REQ_WRITE;
    it.instr       = $urandom;
    it.reg_index   = idx;
    it.write_value = val;
    return it;
  endfunction

  function automatic rv64dr_pkg::in_item_t make_decode(logic [31:0] ins);
    rv64dr_pkg::in_item_t it;
    it.req_type    = rv64dr_pkg::REQ_DECODE;
    it.instr       = ins;
    it.reg_index   = 5'($urandom_range(31));
    it.write_value = {$urandom, $urandom};
    return it;
  endfunction

  function automatic rv64dr_pkg::in_item_t random_item();
    logic [31:0] ins;
    logic [63:0] val;
    int unsigned pick;
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(9))
        0:       val = '0;
        1:       val = '1;
        2:       val = 64'h8000_0000_0000_0000;
        3:       val = 64'h7fff_ffff_ffff_ffff;
        default: val = {$urandom, $urandom};
      endcase
      return make_write(5'($urandom_range(31)), val);
    end
    // Mostly legal 32-bit encodings; the rest are compressed or arbitrary words.
    pick = $urandom_range(99);
    ins  = $urandom;
    if (pick < 85) begin
      ins[6:0] = {well_formed_ops[4'($urandom_range(11))], rv64dr_pkg::QUAD_WIDE};
    end else if (pick < 93) begin
      ins[1:0] = 2'($urandom_range(2));
    end
    return make_decode(ins);
  endfunction

  task automatic send_item(input rv64dr_pkg::in_item_t it);
    while (tx_idle_on && $urandom_range(99) < 25) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    sb.note_request(it);
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic receive_results();
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_decoded(rsp_ch.data);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !(rx_idle_on && $urandom_range(99) < 25);
      end
    end
  endtask

  task automatic run_directed();
    logic [31:0] words[20];
    words = '{
      {7'h7f, 5'd1, 5'd31, 3'd7, 5'd31, OPC_OP},
      {7'h20, 5'd2, 5'd0, 3'd0, 5'd3, OPC_OP32},
      {12'hfff, 5'd2, 3'd3, 5'd4, OPC_LOAD},
      {12'h7ff, 5'd0, 3'd0, 5'd0, OPC_OPIMM},
      {12'h800, 5'd31, 3'd1, 5'd9, OPC_OPIMM32},
      {12'h001, 5'd5, 3'd0, 5'd1, OPC_JALR},
      {12'h000, 5'd0, 3'd0, 5'd0, OPC_SYSTEM},
      {7'h40, 5'd5, 5'd31, 3'd3, 5'd0, OPC_STORE},
      {7'h3f, 5'd2, 5'd1, 3'd2, 5'h1f, OPC_STORE},
      {1'b1, 6'h3f, 5'd5, 5'd1, 3'd7, 4'hf, 1'b1, OPC_BRANCH},
      {1'b0, 6'h3f, 5'd0, 5'd2, 3'd0, 4'hf, 1'b0, OPC_BRANCH},
      {20'hfffff, 5'd31, OPC_JAL},
      {20'h7ffff, 5'd1, OPC_JAL},
      {20'hfffff, 5'd7, OPC_LUI},
      {20'h80000, 5'd0, OPC_AUIPC},
      32'hffff_ffff,
      32'h0000_000b,
      32'h0000_0000,
      32'hffff_fffe,
      32'hffff_fffd
    };
    // The write to x0 must not show up in the reads that follow.
    send_item(make_write(5'd0, '1));
    send_item(make_write(5'd31, 64'h8000_0000_0000_0000));
    send_item(make_write(5'd1, 64'h7fff_ffff_ffff_ffff));
    send_item(make_write(5'd5, '1));
    foreach (words[i]) send_item(make_decode(words[i]));
    // A write is visible to the decode right behind it.
    send_item(make_write(5'd7, 64'h0123_4567_89ab_cdef));
    send_item(make_decode({7'h00, 5'd7, 5'd7, 3'd0, 5'd7, OPC_OP}));
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    rsp_ch.ready <= 1'b0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    rx_hold_left = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    fork
      receive_results();
    join_none

    run_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 0) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (i == 300) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      // Receiver stalls for a long stretch while the sender keeps offering.
      if (i == 500) rx_hold_left = HOLD_CYCLES;
      if (i == 800) wait_all_results();
      send_item(random_item());
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
